@@ hw/rtl/sslc_pkg.sv @@
// Shared types and constants of the strided store line coalescer.
`default_nettype none
package sslc_pkg;

  localparam int unsigned MaxRun   = 16;
  localparam int unsigned RunW     = 5;
  localparam int unsigned IdxW     = 16;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned ValW     = 64;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_BASE   = 3'd0,
    CFG_STRIDE = 3'd1,
    CFG_GLEN   = 3'd2,
    CFG_GSKIP  = 3'd3,
    CFG_DPREC  = 3'd4,
    CFG_SCR    = 3'd5,
    CFG_TOTAL  = 3'd6,
    CFG_UNUSED = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_SUM, ST_WALK, ST_READ, ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [AddrW-1:0] base_addr;
    logic [15:0]      elem_stride;
    logic [15:0]      group_len;
    logic [15:0]      group_skip;
    logic             double_prec;
    logic             to_scratch;
    logic [15:0]      total_count;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [ValW-1:0] value;
    logic            mem_accept;
  } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/strided_store_line_coalescer.sv @@
// Top level of the strided store line coalescer: configuration registers and wiring.
`default_nettype none
// Vector store unit. A start request opens a store of total_count elements, push
// requests fill an element queue of QUEUE_DEPTH entries, and each tick with a memory
// grant writes one coalesced run of contiguous elements inside one line (at most 16),
// one result per element, last_in_request on tlast. Requests are processed one at a
// time behind a two-entry command queue. A granted tick runs the group divide, the address
// multiply-add and the run walk, then a read and an emit for each element of the run.
// Line sizes must be powers of two. Configuration must be written only while no request
// is in flight; the block itself does not enforce it.
module strided_store_line_coalescer #(
  parameter int unsigned QUEUE_DEPTH        = 32,
  parameter int unsigned CACHE_LINE_BYTES   = 64,
  parameter int unsigned SCRATCH_LINE_BYTES = 64
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [2:0]                      cfg_index_i,
  input  wire [31:0]                     cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [sslc_pkg::InDataW-1:0]    s_axis_tdata,  // element_value[63:0], mem_accept[64]
  input  wire [1:0]                      s_axis_tuser,  // kind[1:0]
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [sslc_pkg::OutDataW-1:0]  m_axis_tdata,  // write_addr[31:0], write_value[95:32],
                                                         // vector_done[96]
  output logic [1:0]                     m_axis_tuser,  // write_target[0], queue_overflow[1]
  output logic                           m_axis_tlast   // last_in_request
);
  import sslc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_addr   <= '0;
      cfg_q.elem_stride <= 16'd1;
      cfg_q.group_len   <= 16'd1;
      cfg_q.group_skip  <= '0;
      cfg_q.double_prec <= 1'b0;
      cfg_q.to_scratch  <= 1'b0;
      cfg_q.total_count <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BASE:   cfg_q.base_addr   <= cfg_data_i;
        CFG_STRIDE: cfg_q.elem_stride <= cfg_data_i[15:0];
        CFG_GLEN:   cfg_q.group_len   <= cfg_data_i[15:0];
        CFG_GSKIP:  cfg_q.group_skip  <= cfg_data_i[15:0];
        CFG_DPREC:  cfg_q.double_prec <= cfg_data_i[0];
        CFG_SCR:    cfg_q.to_scratch  <= cfg_data_i[0];
        CFG_TOTAL:  cfg_q.total_count <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  sslc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  sslc_back #(
    .QUEUE_DEPTH        (QUEUE_DEPTH),
    .CACHE_LINE_BYTES   (CACHE_LINE_BYTES),
    .SCRATCH_LINE_BYTES (SCRATCH_LINE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

@@ hw/rtl/sslc_front.sv @@
// Front end: classifies incoming requests into commands and queues them.
`default_nettype none
module sslc_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire [sslc_pkg::InDataW-1:0]   s_axis_tdata,   // element_value[63:0], mem_accept[64]
  input  wire [1:0]                     s_axis_tuser,   // kind[1:0]
  output logic                          cmd_valid_o,
  input  wire                           cmd_ready_i,
  output sslc_pkg::cmd_t                cmd_o
);
  import sslc_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    case (s_axis_tuser)
      KIND_PUSH:  cmd_in.kind = KIND_PUSH;
      KIND_TICK:  cmd_in.kind = KIND_TICK;
      KIND_START: cmd_in.kind = KIND_START;
      default:    cmd_in.kind = KIND_NONE;
    endcase
    cmd_in.value      = s_axis_tdata[ValW-1:0];
    cmd_in.mem_accept = s_axis_tdata[ValW];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sslc_back.sv @@
// Back end: element queue, address generation, run walk and result output.
`default_nettype none
module sslc_back #(
  parameter int unsigned QUEUE_DEPTH        = 32,
  parameter int unsigned CACHE_LINE_BYTES   = 64,
  parameter int unsigned SCRATCH_LINE_BYTES = 64
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  sslc_pkg::cfg_t                 cfg_i,
  input  wire                            cmd_valid_i,
  output logic                           cmd_ready_o,
  input  sslc_pkg::cmd_t                 cmd_i,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [sslc_pkg::OutDataW-1:0]  m_axis_tdata,  // write_addr[31:0], write_value[95:32],
                                                         // vector_done[96], zero pad
  output logic [1:0]                     m_axis_tuser,  // write_target[0], queue_overflow[1]
  output logic                           m_axis_tlast   // last_in_request
);
  import sslc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(QUEUE_DEPTH);
  // line sizes must be powers of two up to 256 bytes; the block itself does not enforce it
  localparam logic [8:0] CacheLine = 9'(CACHE_LINE_BYTES);
  localparam logic [8:0] ScrLine   = 9'(SCRATCH_LINE_BYTES);

  logic [ValW-1:0] mem_q [QUEUE_DEPTH];
  logic [ValW-1:0] rd_data_q;

  back_state_e state_q, state_d;
  logic              busy_q, busy_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [4:0]        div_cnt_q, div_cnt_d;
  logic [15:0]       quot_q, quot_d;
  logic [15:0]       rem_q, rem_d;
  logic [31:0]       prod1_q, prod1_d, prod2_q, prod2_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [RunW-1:0]   run_q, run_d, pos_q, pos_d;
  logic              mem_we;

  logic              out_valid_q, out_valid_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic [ValW-1:0]   out_val_q, out_val_d;
  logic              out_tgt_q, out_tgt_d, out_last_q, out_last_d;
  logic              out_done_q, out_done_d, out_ovf_q, out_ovf_d;

  logic              out_free;
  logic [16:0]       rem_sh;
  logic [32:0]       offset;
  logic [8:0]        line_bytes, step_bytes, line_ofs;
  logic              wrap, contiguous;
  logic [15:0]       rem_next;
  logic [PtrW-1:0]   head_inc, tail_inc;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign head_inc   = (head_q == PtrLast) ? '0 : head_q + 1'b1;
  assign tail_inc   = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
  assign rem_sh     = {rem_q, quot_q[15]};
  assign offset     = {1'b0, prod1_q} + {1'b0, prod2_q};
  assign line_bytes = cfg_i.to_scratch ? ScrLine : CacheLine;
  assign step_bytes = cfg_i.double_prec ? {1'b0, run_q, 3'b000} : {2'b00, run_q, 2'b00};
  assign line_ofs   = ({1'b0, addr_q[7:0]} & (line_bytes - 9'd1)) + step_bytes;
  // group boundary between the last run element and the candidate
  assign wrap       = (cfg_i.group_len != 16'd0) && (rem_q + 16'd1 == cfg_i.group_len);
  assign rem_next   = wrap ? 16'd0 : rem_q + 16'd1;
  assign contiguous = ({1'b0, cfg_i.elem_stride} + (wrap ? {1'b0, cfg_i.group_skip} : 17'd0))
                      == 17'd1;

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    div_cnt_d   = div_cnt_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    addr_d      = addr_q;
    run_d       = run_q;
    pos_d       = pos_q;
    mem_we      = 1'b0;
    cmd_ready_o = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_addr_d  = out_addr_q;
    out_val_d   = out_val_q;
    out_tgt_d   = out_tgt_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_ovf_d   = out_ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.kind)
            KIND_START: begin
              head_d = '0;
              tail_d = '0;
              fill_d = '0;
              idx_d  = '0;
              busy_d = (cfg_i.total_count != 16'd0);
            end
            KIND_PUSH: begin
              if (busy_q) begin
                if (fill_q == FillFull) begin
                  if (out_free) begin
                    out_valid_d = 1'b1;
                    out_addr_d  = '0;
                    out_val_d   = '0;
                    out_tgt_d   = 1'b0;
                    out_last_d  = 1'b0;
                    out_done_d  = 1'b0;
                    out_ovf_d   = 1'b1;
                  end else begin
                    cmd_ready_o = 1'b0;
                  end
                end else begin
                  mem_we = 1'b1;
                  tail_d = tail_inc;
                  fill_d = fill_q + 1'b1;
                end
              end
            end
            KIND_TICK: begin
              if (busy_q) begin
                if (idx_q >= cfg_i.total_count) begin
                  busy_d = 1'b0;
                end else if (fill_q != '0 && cmd_i.mem_accept) begin
                  div_cnt_d = 5'd16;
                  quot_d    = idx_q;
                  rem_d     = '0;
                  state_d   = ST_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // restoring divide: idx / group_len, one quotient bit per cycle
        if (rem_sh >= {1'b0, cfg_i.group_len}) begin
          rem_d  = 16'(rem_sh - {1'b0, cfg_i.group_len});
          quot_d = {quot_q[14:0], 1'b1};
        end else begin
          rem_d  = rem_sh[15:0];
          quot_d = {quot_q[14:0], 1'b0};
        end
        div_cnt_d = div_cnt_q - 5'd1;
        if (div_cnt_q == 5'd1) state_d = ST_MUL1;
      end
      ST_MUL1: begin
        if (cfg_i.group_len == 16'd0) begin
          quot_d = '0;
          rem_d  = '0;
        end
        prod1_d = cfg_i.elem_stride * idx_q;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod2_d = cfg_i.group_skip * quot_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        addr_d  = cfg_i.base_addr + (cfg_i.double_prec ? {offset[28:0], 3'b000}
                                                       : {offset[29:0], 2'b00});
        run_d   = 5'd1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (32'(run_q) < MaxRun && FillW'(run_q) < fill_q &&
            ({1'b0, idx_q} + {12'd0, run_q}) < {1'b0, cfg_i.total_count} &&
            contiguous && line_ofs < line_bytes) begin
          run_d = run_q + 5'd1;
          rem_d = rem_next;
        end else begin
          pos_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = addr_q + (cfg_i.double_prec ? {24'd0, pos_q, 3'b000}
                                                    : {25'd0, pos_q, 2'b00});
          out_val_d   = cfg_i.double_prec ? rd_data_q : {32'd0, rd_data_q[31:0]};
          out_tgt_d   = cfg_i.to_scratch;
          out_last_d  = (pos_q + 5'd1 == run_q);
          out_done_d  = ({1'b0, idx_q} + {12'd0, pos_q} + 17'd1) == {1'b0, cfg_i.total_count};
          out_ovf_d   = 1'b0;
          head_d      = head_inc;
          fill_d      = fill_q - 1'b1;
          pos_d       = pos_q + 5'd1;
          if (pos_q + 5'd1 == run_q) begin
            idx_d   = idx_q + {11'd0, run_q};
            if (({1'b0, idx_q} + {12'd0, run_q}) >= {1'b0, cfg_i.total_count}) begin
              busy_d = 1'b0;
            end
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[tail_q] <= cmd_i.value;
    rd_data_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      div_cnt_q   <= '0;
      run_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      div_cnt_q   <= div_cnt_d;
      run_q       <= run_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    prod1_q    <= prod1_d;
    prod2_q    <= prod2_d;
    addr_q     <= addr_d;
    out_addr_q <= out_addr_d;
    out_val_q  <= out_val_d;
    out_tgt_q  <= out_tgt_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_done_q, out_val_q, out_addr_q};
  assign m_axis_tuser  = {out_ovf_q, out_tgt_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

@@ verif/strided_store_line_coalescer_tb.sv @@
// Self-checking testbench of the strided store line coalescer: directed cases and random streams against a predictor.
`default_nettype none
module strided_store_line_coalescer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sslc_pkg::*;

  localparam int unsigned QDEPTH = 32;
  localparam int unsigned LINE_B = 64;
  localparam int unsigned SLINE_B = 64;
  localparam int unsigned LIMIT = 2000000;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic        accept;
  } req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [63:0] value;
    logic        target;
    logic        last;
    logic        done;
    logic        ovf;
  } wr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  strided_store_line_coalescer uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] p_base;
  logic [15:0] p_stride, p_glen, p_gskip, p_total;
  logic p_dprec, p_scr;
  logic [63:0] elem_fifo[$];
  int unsigned p_index;
  bit p_busy;

  req_t pending_reqs[$];
  wr_t expected_writes[$];
  bit failed = 1'b0;
  bit src_fire = 1'b0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned cycles = 0;

  function automatic logic [31:0] elem_address(int unsigned i, int unsigned size);
    longint unsigned grp, off;
    grp = (p_glen != 0) ? longint'(i / p_glen) : 0;
    off = longint'(p_stride) * i + longint'(p_gskip) * grp;
    return 32'(longint'(p_base) + longint'(size) * off);
  endfunction

  task automatic predict_request(req_t r);
    wr_t w;
    int unsigned size, line, per_line, run, take;
    logic [31:0] a0, l0, na;
    case (r.kind)
      KIND_START: begin
        elem_fifo.delete();
        p_index = 0;
        p_busy = (p_total != 0);
      end
      KIND_PUSH: begin
        if (p_busy) begin
          if (elem_fifo.size() >= QDEPTH) begin
            w = '0;
            w.ovf = 1'b1;
            expected_writes = {expected_writes, w};
          end else elem_fifo = {elem_fifo, r.value};
        end
      end
      KIND_TICK: begin
        if (p_busy) begin
          if (p_index >= p_total) p_busy = 1'b0;
          else if (elem_fifo.size() != 0 && r.accept) begin
            size = p_dprec ? 8 : 4;
            line = p_scr ? SLINE_B : LINE_B;
            a0 = elem_address(p_index, size);
            l0 = a0 - (a0 % line);
            per_line = line / size;
            run = 1;
            for (int unsigned j = 1; j < per_line && j < MaxRun && p_index + j < p_total;
                 j++) begin
              na = elem_address(p_index + j, size);
              if (32'(na - size * j) == a0 && (na - (na % line)) == l0) run++;
              else break;
            end
            take = run < elem_fifo.size() ? run : elem_fifo.size();
            for (int unsigned j = 0; j < take; j++) begin
              w.addr = 32'(a0 + size * j);
              w.value = p_dprec ? elem_fifo[0] : {32'd0, elem_fifo[0][31:0]};
              w.target = p_scr;
              w.last = (j + 1 == take);
              w.done = (p_index + j + 1 == p_total);
              w.ovf = 1'b0;
              elem_fifo.delete(0);
              expected_writes = {expected_writes, w};
            end
            p_index = (p_index + take) & 16'hffff;
            if (p_index >= p_total) p_busy = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (src_fire) begin
        predict_request(pending_reqs[0]);
        pending_reqs.delete(0);
      end
      if (!(s_tvalid && !src_fire)) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (src_idle_en && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 19);
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_reqs[0].kind;
          s_tdata <= {7'd0, pending_reqs[0].accept, pending_reqs[0].value};
        end else s_tvalid <= 1'b0;
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 19);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    wr_t got, exp_w;
    cycles++;
    src_fire <= rst_n && s_tvalid && s_tready;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && m_tvalid && m_tready) begin
      got.addr = m_tdata[31:0];
      got.value = m_tdata[95:32];
      got.done = m_tdata[96];
      got.target = m_tuser[0];
      got.ovf = m_tuser[1];
      got.last = m_tlast;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        exp_w = expected_writes[0];
        expected_writes.delete(0);
        if (got.addr !== exp_w.addr)
          $display("%0t: addr expected %h actual %h", $time, exp_w.addr, got.addr);
        if (got.value !== exp_w.value)
          $display("%0t: value expected %h actual %h", $time, exp_w.value, got.value);
        if (got.target !== exp_w.target)
          $display("%0t: target expected %b actual %b", $time, exp_w.target, got.target);
        if (got.last !== exp_w.last)
          $display("%0t: last expected %b actual %b", $time, exp_w.last, got.last);
        if (got.done !== exp_w.done)
          $display("%0t: done expected %b actual %b", $time, exp_w.done, got.done);
        if (got.ovf !== exp_w.ovf)
          $display("%0t: overflow expected %b actual %b", $time, exp_w.ovf, got.ovf);
        if (got !== exp_w) failed = 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE: p_base = val;
      CFG_STRIDE: p_stride = val[15:0];
      CFG_GLEN: p_glen = val[15:0];
      CFG_GSKIP: p_gskip = val[15:0];
      CFG_DPREC: p_dprec = val[0];
      CFG_SCR: p_scr = val[0];
      CFG_TOTAL: p_total = val[15:0];
      default: ;
    endcase
  endtask

  // wait for the block to drain, then let a slow run finish
  task automatic drain();
    while (pending_reqs.size() != 0 || s_tvalid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic add_req(kind_e k, logic [63:0] v, logic acc);
    req_t r;
    r.kind = k;
    r.value = v;
    r.accept = acc;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_all(logic [31:0] b, logic [15:0] st, logic [15:0] gl, logic [15:0] gs,
                           logic dp, logic sc, logic [15:0] tc);
    write_reg(CFG_BASE, b);
    write_reg(CFG_STRIDE, {16'($urandom_range(0, 65535)), st});
    write_reg(CFG_GLEN, {16'd0, gl});
    write_reg(CFG_GSKIP, {16'd0, gs});
    write_reg(CFG_DPREC, {31'd0, dp});
    write_reg(CFG_SCR, {31'd0, sc});
    write_reg(CFG_TOTAL, {16'd0, tc});
  endtask

  initial begin
    int unsigned n, tc;
    p_base = '0; p_stride = 16'd1; p_glen = 16'd1; p_gskip = '0;
    p_dprec = 1'b0; p_scr = 1'b0; p_total = 16'd1;
    p_index = 0; p_busy = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle push/tick, unused kind, scalar store, overflow
    add_req(KIND_PUSH, '1, 1'b1);
    add_req(KIND_TICK, '0, 1'b1);
    add_req(KIND_NONE, '1, 1'b1);
    add_req(KIND_START, '0, 1'b0);
    add_req(KIND_PUSH, 64'hffff_ffff_ffff_ffff, 1'b0);
    add_req(KIND_TICK, '0, 1'b0);
    add_req(KIND_TICK, '0, 1'b1);
    drain();
    write_all(32'hffff_fff8, 16'd1, 16'd0, 16'd65535, 1'b1, 1'b1, 16'd40);
    add_req(KIND_START, '0, 1'b0);
    for (int i = 0; i < 33; i++) add_req(KIND_PUSH, rand64(), 1'b0);
    add_req(KIND_TICK, '0, 1'b1);
    add_req(KIND_TICK, '0, 1'b1);
    drain();
    // lower count while busy, then zero count start
    write_all(32'h0, 16'd65535, 16'd65535, 16'd0, 1'b0, 1'b0, 16'd5);
    add_req(KIND_START, '0, 1'b0);
    add_req(KIND_PUSH, rand64(), 1'b0);
    add_req(KIND_TICK, '0, 1'b1);
    drain();
    write_reg(CFG_TOTAL, 32'd0);
    add_req(KIND_TICK, '0, 1'b1);
    add_req(KIND_START, '0, 1'b0);
    add_req(KIND_PUSH, rand64(), 1'b0);
    add_req(KIND_TICK, '0, 1'b1);
    drain();

    // random phases of well-formed vectors with noise
    for (int ph = 0; ph < 6; ph++) begin
      if (ph >= 4) begin
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      tc = $urandom_range(1, 24);
      write_all($urandom(), (ph % 3 == 0) ? 16'd1 : 16'($urandom_range(0, 3)),
                16'($urandom_range(0, 5)), 16'($urandom_range(0, 2)),
                1'($urandom), 1'($urandom), 16'(tc));
      add_req(KIND_START, '0, 1'b0);
      n = 0;
      while (n < 18) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: add_req(KIND_PUSH, rand64(), 1'b0);
          5, 6, 7: add_req(KIND_TICK, rand64(), 1'($urandom_range(0, 4) != 0));
          8: add_req(KIND_NONE, rand64(), 1'($urandom));
          default: if ($urandom_range(0, 3) == 0) add_req(KIND_START, '0, 1'b0);
                   else add_req(KIND_TICK, '0, 1'b1);
        endcase
        n++;
      end
      for (int i = 0; i < 6; i++) add_req(KIND_TICK, '0, 1'b1);
      if (ph == 2) begin
        // hold off until every expected write is back
        while (pending_reqs.size() != 0 || s_tvalid || expected_writes.size() != 0)
          @(posedge clk);
      end
      drain();
    end

    drain();
    if (failed || expected_writes.size() != 0) $display("TEST FAILED");
    else $display("TEST PASSED");
    $finish;
  end
endmodule
`default_nettype wire

@@ strided_store_line_coalescer.f @@
hw/rtl/sslc_pkg.sv
hw/rtl/sslc_front.sv
hw/rtl/sslc_back.sv
hw/rtl/strided_store_line_coalescer.sv
verif/strided_store_line_coalescer_tb.sv
